FILE: hw/rtl/catch_handler_list_decoder_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef CATCH_HANDLER_LIST_DECODER_MACROS_SVH
`define CATCH_HANDLER_LIST_DECODER_MACROS_SVH

// Checked at every clock edge outside reset.
`define CHLD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CHLD_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/chld_pkg.sv
`default_nettype none

package chld_pkg;

	localparam int unsigned MAX_LEB_BYTES_DEF = 5;
	localparam int unsigned OFFSET_BITS_DEF   = 20;

	localparam logic [31:0] CATCH_ALL_TYPE = 32'hFFFF_FFFF;
	localparam logic [31:0] HANDLER_LIMIT  = 32'h0000_FFFF;
	localparam logic [31:0] OFFSET_CLAMP   = 32'h000F_FFFF;

	typedef enum logic [5:0] {
		PH_LIST_SIZE  = 6'b000001,
		PH_COUNT      = 6'b000010,
		PH_TYPE       = 6'b000100,
		PH_ADDR_TYPED = 6'b001000,
		PH_ADDR_ALL   = 6'b010000,
		PH_HALT       = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [15:0] handler_number;
		logic [19:0] handler_offset;
		logic [31:0] type_index;
		logic        catch_all;
		logic [31:0] target_address;
		logic        last_in_handler;
		logic        last_in_list;
		logic        format_error;
	} result_t;

	typedef struct packed {
		logic [31:0] value;
		logic        done;
		logic        overlong;
	} leb_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/chld_leb.sv
`default_nettype none

module chld_leb import chld_pkg::*; #(
	parameter int unsigned MAX_LEB_BYTES = MAX_LEB_BYTES_DEF,
	localparam int unsigned CNT_W = $clog2(MAX_LEB_BYTES + 1)
) (
	input  wire logic [31:0]      value_in,
	input  wire logic [CNT_W-1:0] count_in,
	input  wire logic [7:0]       data_byte,
	input  wire logic             is_signed,
	output leb_out_t              res,
	output logic [CNT_W-1:0]      count_next
);

	logic [CNT_W-1:0] cnt_inc;
	logic [6:0]       shift_amt;
	logic [6:0]       sign_amt;
	logic [63:0]      part;
	logic [63:0]      fill;

	always_comb begin
		cnt_inc   = count_in + CNT_W'(1);
		shift_amt = 7'(count_in) * 7'd7;
		sign_amt  = 7'(cnt_inc) * 7'd7;
		part      = 64'(data_byte[6:0]) << shift_amt;
		fill      = ~((64'd1 << sign_amt) - 64'd1);

		res.value    = value_in | part[31:0];
		res.done     = !data_byte[7];
		res.overlong = data_byte[7] && (32'(cnt_inc) >= 32'(MAX_LEB_BYTES));
		// A signed value is sign-extended from the last byte it has.
		if (res.done && is_signed && data_byte[6] && (sign_amt < 7'd32)) begin
			res.value = res.value | fill[31:0];
		end
		count_next = cnt_inc;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/chld_core.sv
`default_nettype none

module chld_core import chld_pkg::*; #(
	parameter int unsigned MAX_LEB_BYTES = MAX_LEB_BYTES_DEF,
	parameter int unsigned OFFSET_BITS   = OFFSET_BITS_DEF,
	localparam int unsigned CNT_W = $clog2(MAX_LEB_BYTES + 1)
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] data_byte,
	input  wire logic       list_start,
	output logic            produced,
	output result_t         result
);

	phase_t                 phase_q, cur_phase, nxt_phase;
	logic [31:0]            leb_value_q, cur_val, nxt_val;
	logic [CNT_W-1:0]       leb_cnt_q, cur_cnt, nxt_cnt;
	logic [15:0]            handlers_left_q, cur_hl, nxt_hl, hl_dec;
	logic [31:0]            pairs_left_q, cur_pairs, nxt_pairs, count_pairs;
	logic                   catch_all_q, cur_cap, nxt_cap;
	logic [31:0]            pending_type_q, cur_pt, nxt_pt;
	logic [OFFSET_BITS-1:0] byte_pos_q, cur_pos, nxt_pos;
	logic [OFFSET_BITS-1:0] handler_begin_q, cur_hb, nxt_hb, hb_eff;
	logic [15:0]            handler_seen_q, cur_seen, nxt_seen;

	leb_out_t         leb_res;
	logic [CNT_W-1:0] leb_cnt_next;
	logic [31:0]      hb_wide;
	logic             neg_count;
	logic             res_all, res_lh, res_ll, res_err;
	logic [31:0]      res_type;

	// A list start restarts parsing from the reset state with this byte.
	always_comb begin
		cur_phase = list_start ? PH_LIST_SIZE : phase_q;
		cur_val   = list_start ? '0 : leb_value_q;
		cur_cnt   = list_start ? '0 : leb_cnt_q;
		cur_hl    = list_start ? '0 : handlers_left_q;
		cur_pairs = list_start ? '0 : pairs_left_q;
		cur_cap   = list_start ? 1'b0 : catch_all_q;
		cur_pt    = list_start ? '0 : pending_type_q;
		cur_pos   = list_start ? '0 : byte_pos_q;
		cur_hb    = list_start ? '0 : handler_begin_q;
		cur_seen  = list_start ? '0 : handler_seen_q;
	end

	chld_leb #(
		.MAX_LEB_BYTES(MAX_LEB_BYTES)
	) u_leb (
		.value_in  (cur_val),
		.count_in  (cur_cnt),
		.data_byte (data_byte),
		.is_signed (cur_phase == PH_COUNT),
		.res       (leb_res),
		.count_next(leb_cnt_next)
	);

	always_comb begin
		hb_eff = ((cur_phase == PH_COUNT) && (cur_cnt == '0)) ? cur_pos : cur_hb;

		nxt_phase   = cur_phase;
		nxt_val     = cur_val;
		nxt_cnt     = cur_cnt;
		nxt_hl      = cur_hl;
		nxt_pairs   = cur_pairs;
		nxt_cap     = cur_cap;
		nxt_pt      = cur_pt;
		nxt_pos     = cur_pos;
		nxt_hb      = cur_hb;
		nxt_seen    = cur_seen;
		neg_count   = 1'b0;
		count_pairs = '0;
		hl_dec      = cur_hl;
		produced    = 1'b0;
		res_all     = 1'b0;
		res_lh      = 1'b0;
		res_ll      = 1'b0;
		res_err     = 1'b0;
		res_type    = '0;

		if (cur_phase != PH_HALT) begin
			nxt_hb  = hb_eff;
			nxt_val = leb_res.value;
			nxt_cnt = leb_cnt_next;
			nxt_pos = (&cur_pos) ? cur_pos : cur_pos + OFFSET_BITS'(1);
			if (leb_res.overlong) begin
				produced  = 1'b1;
				res_err   = 1'b1;
				nxt_phase = PH_HALT;
			end else if (leb_res.done) begin
				nxt_val = '0;
				nxt_cnt = '0;
				unique case (cur_phase)
					PH_LIST_SIZE: begin
						if (leb_res.value > HANDLER_LIMIT) begin
							produced  = 1'b1;
							res_err   = 1'b1;
							nxt_phase = PH_HALT;
						end else if (leb_res.value == '0) begin
							nxt_phase = PH_HALT;
						end else begin
							nxt_hl    = leb_res.value[15:0];
							nxt_seen  = '0;
							nxt_phase = PH_COUNT;
						end
					end
					PH_COUNT: begin
						neg_count   = (leb_res.value == '0) || leb_res.value[31];
						count_pairs = neg_count ? (~leb_res.value + 32'd1) : leb_res.value;
						nxt_cap     = neg_count;
						nxt_pairs   = count_pairs;
						nxt_phase   = (count_pairs != '0) ? PH_TYPE : PH_ADDR_ALL;
					end
					PH_TYPE: begin
						nxt_pt    = leb_res.value;
						nxt_pairs = cur_pairs - 32'd1;
						nxt_phase = PH_ADDR_TYPED;
					end
					PH_ADDR_TYPED, PH_ADDR_ALL: begin
						res_all  = (cur_phase == PH_ADDR_ALL);
						res_type = res_all ? CATCH_ALL_TYPE : cur_pt;
						res_lh   = res_all || ((cur_pairs == '0) && !cur_cap);
						res_ll   = res_lh && (cur_hl <= 16'd1);
						produced = 1'b1;
						if (res_all) begin
							nxt_cap = 1'b0;
						end
						if (!res_lh) begin
							nxt_phase = (cur_pairs != '0) ? PH_TYPE : PH_ADDR_ALL;
						end else begin
							hl_dec    = (cur_hl != '0) ? cur_hl - 16'd1 : cur_hl;
							nxt_hl    = hl_dec;
							nxt_seen  = cur_seen + 16'd1;
							nxt_phase = (hl_dec == '0) ? PH_HALT : PH_COUNT;
						end
					end
					default: begin
						nxt_phase = PH_HALT;
					end
				endcase
			end
		end
	end

	always_comb begin
		hb_wide                = 32'(hb_eff);
		result.handler_number  = cur_seen;
		result.handler_offset  = (hb_wide > OFFSET_CLAMP) ? OFFSET_CLAMP[19:0] : hb_wide[19:0];
		result.type_index      = res_type;
		result.catch_all       = res_all;
		result.target_address  = res_err ? '0 : leb_res.value;
		result.last_in_handler = res_lh;
		result.last_in_list    = res_ll;
		result.format_error    = res_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_LIST_SIZE;
			leb_value_q     <= '0;
			leb_cnt_q       <= '0;
			handlers_left_q <= '0;
			pairs_left_q    <= '0;
			catch_all_q     <= 1'b0;
			pending_type_q  <= '0;
			byte_pos_q      <= '0;
			handler_begin_q <= '0;
			handler_seen_q  <= '0;
		end else if (take) begin
			phase_q         <= nxt_phase;
			leb_value_q     <= nxt_val;
			leb_cnt_q       <= nxt_cnt;
			handlers_left_q <= nxt_hl;
			pairs_left_q    <= nxt_pairs;
			catch_all_q     <= nxt_cap;
			pending_type_q  <= nxt_pt;
			byte_pos_q      <= nxt_pos;
			handler_begin_q <= nxt_hb;
			handler_seen_q  <= nxt_seen;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/chld_out_reg.sv
`default_nettype none

module chld_out_reg import chld_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire logic    produced,
	input  wire result_t result_in,
	input  wire logic    m_tready,
	output logic         m_tvalid,
	output result_t      result_q,
	output logic         space
);

	logic valid_q;

	assign space    = !valid_q || m_tready;
	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= produced;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && produced) begin
			result_q <= result_in;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/catch_handler_list_decoder.sv
// Decodes an encoded catch-handler list arriving one byte per transaction and emits
// one transaction per handler entry, with the catch-all entry last in its handler.
// It sustains one byte per clock cycle while the output is not stalled; a result
// passes through the input register, the combinational LEB128 accumulate and phase
// update in the decoder, and the result register before it is offered. Raising
// the start flag restarts parsing at that byte; after an overlong value or list
// size the decoder reports one error and drops bytes until the next start.
`default_nettype none

module catch_handler_list_decoder import chld_pkg::*; #(
	parameter int unsigned MAX_LEB_BYTES = MAX_LEB_BYTES_DEF,
	parameter int unsigned OFFSET_BITS   = OFFSET_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // data_byte
	input  wire logic         s_tuser,  // list_start
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// handler_number, handler_offset, type_index, target_address, zero fill
	output logic [103:0]      m_tdata,
	output logic [2:0]        m_tuser,  // catch_all, last_in_handler, format_error
	output logic              m_tlast   // last_in_list
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       advance;
	logic       space;
	logic       produced;
	result_t    result_c;
	result_t    result_q;

	assign advance  = valid_s1 && space;
	assign s_tready = arst_n && (!valid_s1 || advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	chld_core #(
		.MAX_LEB_BYTES(MAX_LEB_BYTES),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance),
		.data_byte (byte_s1),
		.list_start(start_s1),
		.produced  (produced),
		.result    (result_c)
	);

	chld_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.produced (produced),
		.result_in(result_c),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.result_q (result_q),
		.space    (space)
	);

	assign m_tdata = {4'b0000, result_q.target_address, result_q.type_index,
		result_q.handler_offset, result_q.handler_number};
	assign m_tuser = {result_q.format_error, result_q.last_in_handler, result_q.catch_all};
	assign m_tlast = result_q.last_in_list;

endmodule

`default_nettype wire

FILE: hw/rtl/chld_checker.sv
`default_nettype none
`include "catch_handler_list_decoder_macros.svh"

module chld_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [103:0] m_tdata,
	input wire logic [2:0]   m_tuser,
	input wire logic         m_tlast
);

	`CHLD_ASSERT_RST(a_reset_idle, !arst_n |=> !m_tvalid, "result valid right after reset")

	`CHLD_ASSERT(a_valid_holds, m_tvalid && !m_tready |=> m_tvalid, "stalled result was dropped")

	// An error transaction carries nothing but the handler index and offset.
	`CHLD_ASSERT(a_error_clean, m_tvalid && m_tuser[2] |-> (m_tdata[103:36] == '0) && !m_tlast && (m_tuser[1:0] == 2'b00), "error result has entry fields set")

	`CHLD_ASSERT(a_list_end_in_handler, m_tvalid && m_tlast |-> m_tuser[1], "list ended inside a handler")

	`CHLD_ASSERT(a_catch_all_shape, m_tvalid && m_tuser[0] |-> (m_tdata[67:36] == 32'hFFFF_FFFF) && m_tuser[1], "catch-all entry malformed")

endmodule

bind catch_handler_list_decoder chld_checker u_chld_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

`default_nettype wire
